// File: design/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg: shared types and constants of the polyline mean curvature block
// Field widths, arithmetic widths and the command item passed from the
// front to the back through the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pmc_pkg;

    localparam int COORD_W     = 16;  // Q10.6 coordinate
    localparam int CNT_W       = 9;   // point count and usable length
    localparam int DIFF1_W     = 17;  // central first difference
    localparam int DIFF2_W     = 19;  // second difference
    localparam int PROD_W      = 36;  // cross product terms
    localparam int NUM_W       = 37;  // numerator N
    localparam int SQ_W        = 32;  // one squared difference
    localparam int S_W         = 33;  // S = X^2 + Y^2
    localparam int ROOT_W      = 27;  // floor(sqrt(S * 2^20))
    localparam int SQRT_SHIFT  = 20;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int SQREM_W     = ROOT_W + 2;
    localparam int DEN_W       = 60;  // S * root
    localparam int DVD_W       = 80;  // divider dividend
    localparam int QUO_W       = 35;  // quotient kept below the saturation mark
    localparam int FRAC_SHIFT  = 43;
    localparam int SUM_W       = 48;
    localparam int OUT_W       = 32;
    localparam int DIV5_RECIP  = 3277; // floor(v/5) = (v * 3277) >> 14 for v < 2048
    localparam int DIV5_SHIFT  = 14;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                      has_term;
        logic                      is_last;
        logic [CNT_W-1:0]          len;
        logic signed [DIFF1_W-1:0] dx1;
        logic signed [DIFF1_W-1:0] dy1;
        logic signed [DIFF2_W-1:0] dx2;
        logic signed [DIFF2_W-1:0] dy2;
    } t_cmd;

endpackage

`default_nettype wire

// File: design/pmc_front.sv
// ----------------------------------------------------------------------------
// pmc_front: point intake and classification
// Keeps the three-point window, the point index and the usable length, and
// queues one command for each point that adds a term or ends the list.
// ----------------------------------------------------------------------------
`default_nettype none

module pmc_front import pmc_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [COORD_W-1:0] i_point_x,
    input  wire logic signed [COORD_W-1:0] i_point_y,
    input  wire logic [CNT_W-1:0]          i_point_count,
    input  wire logic                      i_last_point,
    input  wire logic                      i_full,
    output logic                           o_push,
    output t_cmd                           o_cmd
);

    localparam int IDX_W = $clog2(MAX_POINTS + 1);
    localparam int CW    = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int SC_W  = CNT_W + 2;
    localparam int MP_W  = SC_W + DIV5_SHIFT - 2;

    logic signed [COORD_W-1:0] r_wx0, r_wx1, r_wy0, r_wy1;
    logic [IDX_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_len;

    logic [CW-1:0]    cnt_ext, cnt_clamp;
    logic [SC_W-1:0]  scaled;
    logic [MP_W-1:0]  m_prod;
    logic [CNT_W-1:0] m_new, len;
    logic             first, in_range, accept;

    always_comb begin
        cnt_ext   = CW'(i_point_count);
        cnt_clamp = (cnt_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cnt_ext;
        scaled    = {cnt_clamp[CNT_W-1:0], 2'b00};
        m_prod    = MP_W'(scaled) * MP_W'(DIV5_RECIP);
        m_new     = m_prod[MP_W-1 -: CNT_W];
        first     = (r_idx == '0);
        len       = first ? m_new : r_len;
        in_range  = (r_idx >= IDX_W'(2)) && (CW'(r_idx) < CW'(len));
        accept    = i_valid && !i_full;

        o_cmd.has_term = in_range;
        o_cmd.is_last  = i_last_point;
        o_cmd.len      = len;
        o_cmd.dx1      = DIFF1_W'(i_point_x) - DIFF1_W'(r_wx1);
        o_cmd.dy1      = DIFF1_W'(i_point_y) - DIFF1_W'(r_wy1);
        o_cmd.dx2      = DIFF2_W'(i_point_x) - (DIFF2_W'(r_wx0) <<< 1) + DIFF2_W'(r_wx1);
        o_cmd.dy2      = DIFF2_W'(i_point_y) - (DIFF2_W'(r_wy0) <<< 1) + DIFF2_W'(r_wy1);
    end

    assign o_ready = !i_full;
    assign o_push  = accept && (in_range || i_last_point);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wx0 <= '0;
            r_wx1 <= '0;
            r_wy0 <= '0;
            r_wy1 <= '0;
            r_idx <= '0;
            r_len <= '0;
        end else if (accept) begin
            if (i_last_point) begin
                // A finished list leaves the front as after reset.
                r_wx0 <= '0;
                r_wx1 <= '0;
                r_wy0 <= '0;
                r_wy1 <= '0;
                r_idx <= '0;
                r_len <= '0;
            end else begin
                r_wx1 <= r_wx0;
                r_wy1 <= r_wy0;
                r_wx0 <= i_point_x;
                r_wy0 <= i_point_y;
                r_len <= len;
                if (r_idx < IDX_W'(MAX_POINTS)) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: design/pmc_queue.sv
// ----------------------------------------------------------------------------
// pmc_queue: command queue between front and back
// A small first-in first-out store of command items.
// ----------------------------------------------------------------------------
`default_nettype none

module pmc_queue import pmc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_QW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_QW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_QW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_QW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/pmc_div.sv
// ----------------------------------------------------------------------------
// pmc_div: shared restoring divider
// Two quotient bits per cycle over an 80-bit dividend; the quotient is kept
// only up to the point where it is known to saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module pmc_div import pmc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [QUO_W-1:0]      o_quotient,
    output logic                  o_big
);

    localparam int STEPS = DVD_W / 2;
    localparam int SC_W  = $clog2(STEPS);

    logic             r_busy, r_done, r_big;
    logic [SC_W-1:0]  r_step;
    logic [DVD_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_div, r_rem;
    logic [QUO_W-1:0] r_q;

    logic [DEN_W:0]   sh_a, sh_b;
    logic [DEN_W-1:0] rem_a, rem_b;
    logic [QUO_W-1:0] q_a, q_b;
    logic             big_a, big_b, ge_a, ge_b;

    always_comb begin
        sh_a  = {r_rem, r_dvd[DVD_W-1]};
        ge_a  = (sh_a >= {1'b0, r_div});
        rem_a = ge_a ? DEN_W'(sh_a - {1'b0, r_div}) : sh_a[DEN_W-1:0];
        q_a   = r_q;
        big_a = r_big;
        if (!r_big) begin
            q_a   = {r_q[QUO_W-2:0], ge_a};
            big_a = q_a[QUO_W-1];
        end

        sh_b  = {rem_a, r_dvd[DVD_W-2]};
        ge_b  = (sh_b >= {1'b0, r_div});
        rem_b = ge_b ? DEN_W'(sh_b - {1'b0, r_div}) : sh_b[DEN_W-1:0];
        q_b   = q_a;
        big_b = big_a;
        if (!big_a) begin
            q_b   = {q_a[QUO_W-2:0], ge_b};
            big_b = q_b[QUO_W-1];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
    assign o_big      = r_big;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SC_W'(1);
                if (r_step == SC_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 2;
            r_rem <= rem_b;
            r_q   <= q_b;
            r_big <= big_b;
        end
    end

endmodule

`default_nettype wire

// File: design/pmc_back.sv
// ----------------------------------------------------------------------------
// pmc_back: curvature term evaluation and mean
// Takes commands from the queue, forms N and S, takes the square root bit
// by bit, divides on the shared divider, sums terms and produces the mean.
// ----------------------------------------------------------------------------
`default_nettype none

module pmc_back import pmc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_div_start,
    output logic [DVD_W-1:0]      o_div_dividend,
    output logic [DEN_W-1:0]      o_div_divisor,
    input  wire logic             i_div_done,
    input  wire logic [QUO_W-1:0] i_div_quotient,
    input  wire logic             i_div_big,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [OUT_W-1:0]      o_mean_curvature,
    output logic                  o_invalid
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SUM, S_SQRT, S_DEN, S_TSTART, S_TDIV, S_ACC,
        S_FIN, S_MSTART, S_MDIV, S_OUT
    } t_state;

    localparam int SQC_W = $clog2(ROOT_W);
    localparam int XX_W  = 2 * DIFF1_W;
    localparam int SH_W  = SQREM_W + 2;

    t_state                    r_state;
    t_cmd                      r_cmd;
    logic signed [PROD_W-1:0]  r_p1, r_p2;
    logic [SQ_W-1:0]           r_xx, r_yy;
    logic signed [NUM_W-1:0]   r_num;
    logic [S_W-1:0]            r_s;
    logic [RAD_W-1:0]          r_sq_v;
    logic [SQREM_W-1:0]        r_sq_rem;
    logic [ROOT_W-1:0]         r_root;
    logic [SQC_W-1:0]          r_sq_cnt;
    logic [DEN_W-1:0]          r_den;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_out_valid, r_out_invalid;
    logic [OUT_W-1:0]          r_out_mean;

    logic signed [XX_W-1:0]    xx_full, yy_full;
    logic [S_W-1:0]            s_sum;
    logic [SH_W-1:0]           sq_sh, sq_trial;
    logic [NUM_W-1:0]          num_mag;
    logic [SUM_W-1:0]          sum_mag;
    logic [CNT_W-1:0]          cnt_m2;
    logic [QUO_W:0]            q_inc;
    logic [OUT_W-1:0]          term, mean;

    function automatic logic [OUT_W-1:0] sat_signed(input logic neg,
                                                     input logic [QUO_W-1:0] mag,
                                                     input logic big);
        logic [OUT_W-1:0] res;
        if (neg) begin
            if (big || mag > QUO_W'(64'h8000_0000)) begin
                res = 32'h8000_0000;
            end else begin
                res = '0 - mag[OUT_W-1:0];
            end
        end else begin
            if (big || mag > QUO_W'(64'h7FFF_FFFF)) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = mag[OUT_W-1:0];
            end
        end
        return res;
    endfunction

    always_comb begin
        xx_full  = XX_W'(r_cmd.dx1) * XX_W'(r_cmd.dx1);
        yy_full  = XX_W'(r_cmd.dy1) * XX_W'(r_cmd.dy1);
        s_sum    = {1'b0, r_xx} + {1'b0, r_yy};
        sq_sh    = {r_sq_rem, r_sq_v[RAD_W-1 -: 2]};
        sq_trial = SH_W'({r_root, 2'b01});
        num_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
        sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        cnt_m2   = r_cmd.len - CNT_W'(2);
        q_inc    = {1'b0, i_div_quotient} + (QUO_W+1)'(1);
        term     = sat_signed(r_num[NUM_W-1], q_inc[QUO_W:1], i_div_big);
        mean     = sat_signed(r_sum[SUM_W-1], i_div_quotient, i_div_big);

        o_pop       = (r_state == S_IDLE) && !i_empty;
        o_div_start = (r_state == S_TSTART) || (r_state == S_MSTART);
        if (r_state == S_MSTART) begin
            o_div_dividend = DVD_W'({sum_mag, 1'b0}) + DVD_W'(cnt_m2);
            o_div_divisor  = DEN_W'({cnt_m2, 1'b0});
        end else begin
            o_div_dividend = {num_mag, {FRAC_SHIFT{1'b0}}};
            o_div_divisor  = r_den;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mean_curvature = r_out_mean;
    assign o_invalid        = r_out_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= i_cmd.has_term ? S_MUL : S_FIN;
                    end
                end
                S_MUL: begin
                    r_p1    <= PROD_W'(r_cmd.dx1) * PROD_W'(r_cmd.dy2);
                    r_p2    <= PROD_W'(r_cmd.dy1) * PROD_W'(r_cmd.dx2);
                    r_xx    <= xx_full[SQ_W-1:0];
                    r_yy    <= yy_full[SQ_W-1:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_num    <= NUM_W'(r_p1) - NUM_W'(r_p2);
                    r_s      <= s_sum;
                    r_sq_v   <= RAD_W'({s_sum, {SQRT_SHIFT{1'b0}}});
                    r_sq_rem <= '0;
                    r_root   <= '0;
                    r_sq_cnt <= '0;
                    // A zero denominator drops the term.
                    if (s_sum == '0) begin
                        r_state <= r_cmd.is_last ? S_FIN : S_IDLE;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sq_v <= r_sq_v << 2;
                    if (sq_sh >= sq_trial) begin
                        r_sq_rem <= SQREM_W'(sq_sh - sq_trial);
                        r_root   <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_sq_rem <= sq_sh[SQREM_W-1:0];
                        r_root   <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_sq_cnt <= r_sq_cnt + SQC_W'(1);
                    if (r_sq_cnt == SQC_W'(ROOT_W - 1)) begin
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_den   <= DEN_W'(r_s) * DEN_W'(r_root);
                    r_state <= S_TSTART;
                end
                S_TSTART: begin
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    if (i_div_done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum   <= r_sum + SUM_W'(signed'(term));
                    r_state <= r_cmd.is_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    if (r_cmd.len <= CNT_W'(2)) begin
                        r_out_valid   <= 1'b1;
                        r_out_invalid <= 1'b1;
                        r_out_mean    <= '0;
                        r_sum         <= '0;
                        r_state       <= S_OUT;
                    end else begin
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    if (i_div_done) begin
                        r_out_valid   <= 1'b1;
                        r_out_invalid <= 1'b0;
                        r_out_mean    <= mean;
                        r_sum         <= '0;
                        r_state       <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("result valid outside the output state");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_done |-> ((r_state == S_TDIV) || (r_state == S_MDIV)))
        else $error("divider finished while nobody waits for it");

    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_sq_cnt <= SQC_W'(ROOT_W - 1)))
        else $error("square root ran past its last step");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_sum == '0))
        else $error("sum not cleared after a list result");

endmodule

`default_nettype wire

// File: design/polyline_mean_curvature_top.sv
// ----------------------------------------------------------------------------
// polyline_mean_curvature_top: mean signed curvature of a sampled path
// Points arrive one item at a time; the last point of a list yields one
// result item with the mean curvature in Q8.24 and an invalid flag.
//
// Input channel: i_valid / o_ready with i_point_x, i_point_y (Q10.6),
// i_point_count and i_last_point. Output channel: o_valid / i_ready with
// o_mean_curvature (Q8.24, saturated) and o_invalid.
// The front takes one point per cycle while the four-entry command queue
// has room. Points that add no term and do not end a list never enter the
// queue. A point that adds a term passes through the back's pop, product
// and sum stages, a bit-serial square root, the denominator multiply and
// the two-bit-per-cycle shared divider. The last point adds the mean
// division, and each term queued ahead of it holds back the result.
// The result sits in an output register; while the receiver stalls, the
// back waits there but the front keeps filling the queue until it is full.
// Reset clears the window, index, length, sum, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_mean_curvature_top import pmc_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [COORD_W-1:0] i_point_x,
    input  wire logic signed [COORD_W-1:0] i_point_y,
    input  wire logic [CNT_W-1:0]          i_point_count,
    input  wire logic                      i_last_point,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [OUT_W-1:0]        o_mean_curvature,
    output logic                           o_invalid
);

    // Command path from the front to the back.
    t_cmd push_cmd, pop_cmd;
    logic push, pop, full, empty;

    // Shared divider hookup.
    logic             div_start, div_done, div_big;
    logic [DVD_W-1:0] div_dividend;
    logic [DEN_W-1:0] div_divisor;
    logic [QUO_W-1:0] div_quotient;
    logic [OUT_W-1:0] mean_bits;

    pmc_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_count (i_point_count),
        .i_last_point  (i_last_point),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    pmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    pmc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient),
        .o_big      (div_big)
    );

    pmc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (pop_cmd),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_div_start      (div_start),
        .o_div_dividend   (div_dividend),
        .o_div_divisor    (div_divisor),
        .i_div_done       (div_done),
        .i_div_quotient   (div_quotient),
        .i_div_big        (div_big),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_mean_curvature (mean_bits),
        .o_invalid        (o_invalid)
    );

    assign o_mean_curvature = signed'(mean_bits);

endmodule

`default_nettype wire

// File: dv/tb_polyline_mean_curvature_top.sv
// ----------------------------------------------------------------------------
// tb_polyline_mean_curvature_top: self-checking bench for the curvature block
// Drives path lists point by point, predicts each list's mean curvature and
// invalid flag, and compares every result item against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

// Holds the path state of the block and the queue of predicted results.
class curvature_scoreboard;
    logic signed [31:0] prev_x [2];
    logic signed [31:0] prev_y [2];
    int unsigned        idx;
    int unsigned        usable;
    longint             term_sum;
    logic signed [31:0] mean_q [$];
    bit                 inval_q [$];
    int                 errors;

    function new();
        errors = 0;
        clear_path();
    endfunction

    function void clear_path();
        prev_x[0] = 0; prev_x[1] = 0;
        prev_y[0] = 0; prev_y[1] = 0;
        idx = 0;
        usable = 0;
        term_sum = 0;
    endfunction

    // Integer square root, bit by bit.
    function longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 56;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // One curvature term in Q8.24, rounded and saturated; den must be > 0.
    function longint curv_term(longint num, longint unsigned s);
        bit              neg;
        logic [127:0]    mag;
        logic [127:0]    den;
        logic [127:0]    quo;
        neg = num < 0;
        mag = neg ? -num : num;
        den = s * int_root(s << 20);
        quo = ((mag << 43) / den + 1) >> 1;
        if (neg) begin
            if (quo > 128'd2147483648) quo = 128'd2147483648;
            return -longint'(quo[63:0]);
        end
        if (quo > 128'd2147483647) quo = 128'd2147483647;
        return longint'(quo[63:0]);
    endfunction

    // Accepted input point: update path state, queue a result on the last one.
    function void note_point(logic signed [15:0] px, logic signed [15:0] py,
                             logic [8:0] cnt, bit last);
        longint          dx1, dy1, dx2, dy2, num;
        longint unsigned s, c, mag, q;
        int unsigned     n;
        bit              neg;
        if (idx == 0) begin
            n = (cnt > 256) ? 256 : cnt;
            usable = (4 * n) / 5;
        end
        if (idx >= 2 && idx < usable) begin
            dx1 = longint'(px) - prev_x[1];
            dy1 = longint'(py) - prev_y[1];
            dx2 = longint'(px) - 2 * longint'(prev_x[0]) + prev_x[1];
            dy2 = longint'(py) - 2 * longint'(prev_y[0]) + prev_y[1];
            num = dx1 * dy2 - dy1 * dx2;
            s = dx1 * dx1 + dy1 * dy1;
            // A window with no spread adds nothing.
            if (s != 0) term_sum += curv_term(num, s);
        end
        prev_x[1] = prev_x[0]; prev_y[1] = prev_y[0];
        prev_x[0] = px;        prev_y[0] = py;
        if (idx < 256) idx++;
        if (!last) return;
        if (usable <= 2) begin
            mean_q.push_back(0);
            inval_q.push_back(1);
        end else begin
            c = usable - 2;
            neg = term_sum < 0;
            mag = neg ? -term_sum : term_sum;
            q = (2 * mag + c) / (2 * c);
            if (neg) begin
                if (q > 64'd2147483648) q = 64'd2147483648;
                mean_q.push_back(32'(-longint'(q)));
            end else begin
                if (q > 64'd2147483647) q = 64'd2147483647;
                mean_q.push_back(32'(q));
            end
            inval_q.push_back(0);
        end
        clear_path();
    endfunction

    function void check_result(logic signed [31:0] mean, logic inval, longint t);
        logic signed [31:0] exp_mean;
        bit                 exp_inval;
        if (mean_q.size() == 0) begin
            $display("%0t: unexpected result mean=%0d invalid=%0b", t, mean, inval);
            errors++;
            return;
        end
        exp_mean = mean_q.pop_front();
        exp_inval = inval_q.pop_front();
        if (mean !== exp_mean) begin
            $display("%0t: mean_curvature expected %0d actual %0d", t, exp_mean, mean);
            errors++;
        end
        if (inval !== exp_inval) begin
            $display("%0t: invalid expected %0b actual %0b", t, exp_inval, inval);
            errors++;
        end
    endfunction

    function int pending();
        return mean_q.size();
    endfunction
endclass

module tb_polyline_mean_curvature_top;
    import pmc_pkg::*;

    // The watchdog limit covers the longest queue drain behind a stalled
    // receiver: four queued terms plus the mean division.
    localparam int STALL_LIMIT = 4000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic [CNT_W-1:0]          i_point_count;
    logic                      i_last_point;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [OUT_W-1:0]   o_mean_curvature;
    logic                      o_invalid;

    curvature_scoreboard sb;
    bit                  calm;       // no idling in the closing part of the run
    bit                  stim_done;
    int                  idle_cycles = 0;

    polyline_mean_curvature_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_point_count    (i_point_count),
        .i_last_point     (i_last_point),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_mean_curvature (o_mean_curvature),
        .o_invalid        (o_invalid)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sample both channels at the rising edge. Inputs are noted at acceptance
    // so the prediction follows the order the block sees.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_point(i_point_x, i_point_y, i_point_count, i_last_point);
            if (o_valid && i_ready)
                sb.check_result(o_mean_curvature, o_invalid, $time);
            if ((i_valid && o_ready) || (o_valid && i_ready) || stim_done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: too long with no handshake on either side ends the run.
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver stalls in random bursts, except in the closing part.
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // Presents one point and holds it until the block takes it. Valid stays
    // high into the next point so back-to-back items leave no idle gap.
    task automatic send_point(logic signed [15:0] px, logic signed [15:0] py,
                              logic [8:0] cnt, bit last);
        if (!calm && $urandom_range(0, 6) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_point_x     <= px;
        i_point_y     <= py;
        i_point_count <= cnt;
        i_last_point  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // One list of points along a smooth, jagged or nearly still path; the end can come
    // early, late or on time.
    task automatic send_path(int unsigned cnt, int unsigned len, int shape);
        int x, y, vx, vy;
        x = $urandom_range(0, 4000) - 2000;
        y = $urandom_range(0, 4000) - 2000;
        vx = $urandom_range(0, 200) - 100;
        vy = $urandom_range(0, 200) - 100;
        for (int k = 0; k < len; k++) begin
            case (shape)
                0: begin
                    vx += $urandom_range(0, 20) - 10;
                    vy += $urandom_range(0, 20) - 10;
                    x += vx; y += vy;
                end
                1: begin
                    x = $urandom; y = $urandom;
                end
                default: begin
                    // Repeated points give windows with no spread.
                    if ($urandom_range(0, 2) != 0) begin
                        x += $urandom_range(0, 6) - 3;
                        y += $urandom_range(0, 6) - 3;
                    end
                end
            endcase
            send_point(16'(x), 16'(y), 9'(cnt), k == len - 1);
        end
    endtask

    initial begin
        int unsigned n_items, cnt, len;
        int          r;
        sb = new();
        calm = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_count = '0;
        i_last_point = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: last point as the first item, short invalid lists,
        // coordinate extremes, a count above the maximum and count changes.
        send_point(16'sh7fff, 16'sh8000, 9'd0, 1'b1);
        send_point(16'sh8000, 16'sh7fff, 9'd3, 1'b0);
        send_point(16'sh0000, 16'sh0000, 9'd3, 1'b1);
        send_point(16'sh7fff, 16'sh7fff, 9'd4, 1'b0);
        send_point(16'sh8000, 16'sh8000, 9'd4, 1'b0);
        send_point(16'sh7fff, 16'sh8000, 9'd4, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 9'd4, 1'b1);
        // Alternating extremes drive the second differences near their widest values.
        for (int k = 0; k < 5; k++)
            send_point(k[0] ? 16'sh8000 : 16'sh7fff, k[1] ? 16'sh8000 : 16'sh0001,
                       k == 0 ? 9'd5 : 9'd2, k == 4);
        // Tiny turns on a long baseline and identical points.
        send_point(16'sh0000, 16'sh0000, 9'd511, 1'b0);
        send_point(16'sh0000, 16'sh0000, 9'd0, 1'b0);
        send_point(16'sh0000, 16'sh0000, 9'd0, 1'b0);
        send_point(16'sh0001, 16'sh0000, 9'd0, 1'b0);
        send_point(16'sh0002, 16'sh0001, 9'd0, 1'b1);
        drain_results();

        // Random: mostly short lists, a few at the largest counts.
        n_items = 0;
        while (n_items < 1750) begin
            r = $urandom_range(0, 19);
            cnt = (r == 0) ? $urandom_range(250, 511) : $urandom_range(0, 24);
            case ($urandom_range(0, 5))
                0: len = $urandom_range(1, 4);
                1: len = (cnt > 0) ? $urandom_range(1, cnt) : 1;
                2: len = cnt + $urandom_range(1, 5);
                default: len = (cnt > 0) ? cnt : 1;
            endcase
            if (len > 300) len = 300;
            if (n_items > 1500) calm = 1;
            send_path(cnt, len, $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
            n_items += len;
            // Now and then the sender holds off until every result is back.
            if ($urandom_range(0, 15) == 0) drain_results();
        end

        drain_results();
        stim_done = 1;
        repeat (200) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
